// ===== sv/mms_pkg.sv =====
package mms_pkg;

  // Default sizes of the block.
  localparam int unsigned MAX_COLS_DEF   = 64;
  localparam int unsigned MAX_ROWS_DEF   = 1024;
  localparam int unsigned DEPTH_BITS_DEF = 4;

  // Fixed field and register widths.
  localparam int unsigned FIELD_DEPTH_W = 4;
  localparam int unsigned ROWS_REG_W    = 11;
  localparam int unsigned COLS_REG_W    = 7;
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned CFG_IDX_W     = 1;

  // Register reset values.
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = ROWS_REG_W'(18);
  localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(12);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // Input actions.
  localparam logic ACT_CELL  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Width of a window count (at most nine nonzero cells).
  localparam int unsigned CNT_W = 4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RDC,
    S_CHK,
    S_ACC,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// ===== sv/masked_mean_3x3_smoother.sv =====
// Masked 3x3 mean smoother for a raster stream of depth cells.
// Input channel: in_valid_i / in_stall_o carry one item (action_i, cell_depth_i).
// A cell item writes the cell into a ring memory of 2*MAX_COLS+3 entries; a drain
// item releases one pending cell once the whole frame has been received.
// Output channel: out_valid_o / out_stall_i carry the smoothed cell and frame_last_o.
// A cell leaves one row plus one cell after it entered, in raster order.
// Items are handled one at a time by a sequencer around the ring memory:
// an item that releases nothing passes through S_EVAL only, a border or zero cell
// through S_RDC, S_CHK and S_OUT, and an interior nonzero cell also through S_ACC
// and S_DIV, with nine reads of its window through the one read port of the
// memory and a bit-serial divider.
// Results sit in an output register, so a new item is accepted while a result
// waits; when the receiver stalls, the next result waits in the sequencer and
// the input stalls until the output register is free.
// Reset restores 18 rows and 12 columns and starts an empty frame; the ring
// memory is not cleared, as no entry is read before the frame has written it.
// A configuration write (cfg_we_i, cfg_index_i, cfg_data_i) takes effect at once
// and starts a new frame.
module masked_mean_3x3_smoother #(
  parameter int unsigned MAX_COLS   = mms_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS   = mms_pkg::MAX_ROWS_DEF,
  parameter int unsigned DEPTH_BITS = mms_pkg::DEPTH_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [mms_pkg::FIELD_DEPTH_W-1:0]  cell_depth_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mms_pkg::FIELD_DEPTH_W-1:0]  smoothed_depth_o,
  output logic                               frame_last_o,
  input  logic                               cfg_we_i,
  input  logic [mms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mms_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned WIN    = 2 * MAX_COLS + 3;
  localparam int unsigned AW     = $clog2(WIN);
  localparam int unsigned DB     = DEPTH_BITS;
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned COL_W  = $clog2(MAX_COLS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int unsigned SUM_W  = DB + 4;
  localparam int unsigned CW     = mms_pkg::CNT_W;
  localparam int unsigned RW     = mms_pkg::ROWS_REG_W;
  localparam int unsigned CLW    = mms_pkg::COLS_REG_W;
  localparam int unsigned FW     = mms_pkg::FIELD_DEPTH_W;

  mms_pkg::state_e state_q, state_d;

  logic [RW-1:0]    rows_q, rows_d;
  logic [CLW-1:0]   cols_q, cols_d;
  logic [ROW_W-1:0] nr;
  logic [COL_W-1:0] nc;
  logic [IDX_W-1:0] total_q;
  logic [IDX_W-1:0] in_idx_q, in_idx_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             act_q;
  logic [DB-1:0]    din_q;
  logic [AW-1:0]    win_addr_q, win_addr_d;
  logic [3:0]       k_q, k_d;
  logic [1:0]       j_q, j_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DB-1:0]    res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic [FW-1:0]    out_depth_q, out_depth_d;
  logic             out_last_q, out_last_d;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [DB-1:0]    mem_rdata;
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_quo;

  logic [IDX_W-1:0] in_new, out_new;
  logic [AW:0]      base_wide, step_wide;
  logic [AW-1:0]    base_addr, next_addr;
  logic [SUM_W-1:0] acc_sum;
  logic [CW-1:0]    acc_cnt;
  logic             interior;
  logic             accept;

  // Saturate the frame size registers to the supported range.
  always_comb begin
    if (rows_q == '0) begin
      nr = ROW_W'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      nr = ROW_W'(MAX_ROWS);
    end else begin
      nr = ROW_W'(rows_q);
    end
    if (cols_q == '0) begin
      nc = COL_W'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      nc = COL_W'(MAX_COLS);
    end else begin
      nc = COL_W'(cols_q);
    end
  end

  // Cell count of the frame, registered after the multiplier.
  always_ff @(posedge clk_i) begin
    total_q <= IDX_W'(nr * nc);
  end

  // Ring addresses: window origin one row plus one cell before the centre,
  // and the step to the next window cell.
  always_comb begin
    base_wide = (AW+1)'(rptr_q) + (AW+1)'(WIN) - (AW+1)'(nc) - (AW+1)'(1);
    base_addr = (base_wide >= (AW+1)'(WIN)) ? AW'(base_wide - (AW+1)'(WIN))
                                            : AW'(base_wide);
    if (j_q == 2'd2) begin
      step_wide = (AW+1)'(win_addr_q) + (AW+1)'(nc) - (AW+1)'(2);
    end else begin
      step_wide = (AW+1)'(win_addr_q) + (AW+1)'(1);
    end
    next_addr = (step_wide >= (AW+1)'(WIN)) ? AW'(step_wide - (AW+1)'(WIN))
                                            : AW'(step_wide);
  end

  assign in_new   = in_idx_q + IDX_W'(1);
  assign out_new  = out_idx_q + IDX_W'(1);
  assign acc_sum  = sum_q + SUM_W'(mem_rdata);
  assign acc_cnt  = cnt_q + CW'(mem_rdata != '0);
  assign interior = (mem_rdata != '0) && (row_q != '0) && (col_q != '0) &&
                    ((ROW_W+1)'(row_q) + (ROW_W+1)'(1) < (ROW_W+1)'(nr)) &&
                    ((COL_W+1)'(col_q) + (COL_W+1)'(1) < (COL_W+1)'(nc));
  assign accept   = in_valid_i && !in_stall_o;

  // Sequencer: next state, memory accesses and index updates.
  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    in_idx_d    = in_idx_q;
    out_idx_d   = out_idx_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    row_d       = row_q;
    col_d       = col_q;
    win_addr_d  = win_addr_q;
    k_d         = k_q;
    j_d         = j_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_depth_d = out_depth_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rptr_q;
    div_start   = 1'b0;

    unique case (state_q)
      mms_pkg::S_IDLE: begin
        if (accept) begin
          state_d = mms_pkg::S_EVAL;
        end
      end
      mms_pkg::S_EVAL: begin
        state_d = mms_pkg::S_IDLE;
        if (act_q == mms_pkg::ACT_CELL && in_idx_q < total_q) begin
          // Store the cell; release the centre once its window is complete.
          mem_we   = 1'b1;
          in_idx_d = in_new;
          wptr_d   = (wptr_q == AW'(WIN - 1)) ? '0 : wptr_q + AW'(1);
          if (in_new - out_idx_q >= IDX_W'(nc) + IDX_W'(2) && out_idx_q < total_q) begin
            state_d = mms_pkg::S_RDC;
          end
        end else if (in_idx_q >= total_q && out_idx_q < total_q) begin
          state_d = mms_pkg::S_RDC;
        end
      end
      mms_pkg::S_RDC: begin
        mem_re    = 1'b1;
        mem_raddr = rptr_q;
        state_d   = mms_pkg::S_CHK;
      end
      mms_pkg::S_CHK: begin
        res_d = mem_rdata;
        if (interior) begin
          mem_re     = 1'b1;
          mem_raddr  = base_addr;
          win_addr_d = base_addr;
          k_d        = '0;
          j_d        = '0;
          sum_d      = '0;
          cnt_d      = '0;
          state_d    = mms_pkg::S_ACC;
        end else begin
          state_d = mms_pkg::S_OUT;
        end
      end
      mms_pkg::S_ACC: begin
        // Accumulate one window cell a cycle while the next one is read.
        sum_d = acc_sum;
        cnt_d = acc_cnt;
        if (k_q == 4'd8) begin
          div_start = 1'b1;
          state_d   = mms_pkg::S_DIV;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = next_addr;
          win_addr_d = next_addr;
          k_d        = k_q + 4'd1;
          j_d        = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        end
      end
      mms_pkg::S_DIV: begin
        if (div_done) begin
          res_d   = DB'(div_quo);
          state_d = mms_pkg::S_OUT;
        end
      end
      mms_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_depth_d = FW'(res_q);
          state_d     = mms_pkg::S_IDLE;
          if (out_new >= total_q) begin
            // Final cell: the next item starts a new frame.
            out_last_d = 1'b1;
            out_idx_d  = '0;
            in_idx_d   = '0;
            wptr_d     = '0;
            rptr_d     = '0;
            row_d      = '0;
            col_d      = '0;
          end else begin
            out_last_d = 1'b0;
            out_idx_d  = out_new;
            rptr_d     = (rptr_q == AW'(WIN - 1)) ? '0 : rptr_q + AW'(1);
            if ((COL_W+1)'(col_q) + (COL_W+1)'(1) == (COL_W+1)'(nc)) begin
              col_d = '0;
              row_d = row_q + ROW_W'(1);
            end else begin
              col_d = col_q + COL_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = mms_pkg::S_IDLE;
      end
    endcase

    // Register writes start a new frame.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mms_pkg::CFG_ROWS: rows_d = RW'(cfg_data_i);
        mms_pkg::CFG_COLS: cols_d = CLW'(cfg_data_i);
        default:           rows_d = rows_q;
      endcase
      in_idx_d  = '0;
      out_idx_d = '0;
      wptr_d    = '0;
      rptr_d    = '0;
      row_d     = '0;
      col_d     = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mms_pkg::S_IDLE;
      rows_q      <= mms_pkg::ROWS_RESET;
      cols_q      <= mms_pkg::COLS_RESET;
      in_idx_q    <= '0;
      out_idx_q   <= '0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      in_idx_q    <= in_idx_d;
      out_idx_q   <= out_idx_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      din_q <= DB'(cell_depth_i);
    end
    win_addr_q  <= win_addr_d;
    k_q         <= k_d;
    j_q         <= j_d;
    sum_q       <= sum_d;
    cnt_q       <= cnt_d;
    res_q       <= res_d;
    out_depth_q <= out_depth_d;
    out_last_q  <= out_last_d;
  end

  mms_ring_mem #(
    .DW    (DB),
    .DEPTH (WIN),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wptr_q),
    .wdata_i (din_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mms_divider #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_sum),
    .divisor_i  (acc_cnt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_stall_o       = (state_q != mms_pkg::S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign smoothed_depth_o = out_depth_q;
  assign frame_last_o     = out_last_q;

endmodule

// ===== sv/mms_ring_mem.sv =====
module mms_ring_mem #(
  parameter int unsigned DW    = 4,
  parameter int unsigned DEPTH = 131,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mms_divider.sv =====
module mms_divider #(
  parameter int unsigned SUM_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SUM_W-1:0]           dividend_i,
  input  logic [mms_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [SUM_W-1:0]           quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);
  localparam int unsigned CW     = mms_pkg::CNT_W;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [SUM_W-1:0]    num_q, num_d;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic [CW-1:0]       div_q, div_d;
  logic [CW:0]         rem_sh;
  logic                ge;

  // One quotient bit per cycle, restoring division.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    rem_sh = {rem_q, num_q[SUM_W-1]};
    ge     = rem_sh >= {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      quo_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d  = {num_q[SUM_W-2:0], 1'b0};
      quo_d  = {quo_q[SUM_W-2:0], ge};
      rem_d  = ge ? CW'(rem_sh - {1'b0, div_q}) : CW'(rem_sh);
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
